/* design/csos_pkg.sv */
// Package for the circular segment overlap sum block.
// Holds the sequencer state type, command codes and fixed field widths.
// No dependencies.
package csos_pkg;

  localparam int PERIOD_W = 32;
  localparam int AMOUNT_W = 38;
  localparam int TERM_W   = PERIOD_W + 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = '1;
  localparam logic [AMOUNT_W-1:0] AMOUNT_SAT   = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_OVERLAP,
    CMD_LENGTH
  } csos_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } csos_state_t;

endpackage

/* design/circular_segment_overlap_sum_core.sv */
// Circular segment overlap sum: segment list, shared overlap unit and sequencer.
// Depends on csos_pkg.
//
// Usage overview.
// The block keeps up to MAX_SEGMENTS segments on a circle whose length is the
// period register, to be written by the user through cfg_wr_en / cfg_wr_data
// while idle; the block itself does not enforce this. Requests arrive on the
// in_ channel (valid/ready) and each request yields exactly one response on
// the out_ channel (valid/ready): amount and error. Clear and append finish
// in the cycle after acceptance; the response is registered and loads into
// the output register once that register is free. Overlap and length queries
// walk the stored list through one shared clip-and-subtract unit, one piece
// per cycle. A segment gives one piece, or up to four for an overlap query
// when the segment and the query both wrap through zero. The block takes one
// request at a time: in_ready is high only while the sequencer is idle.
// Synchronous reset clears the list (count zero), sets the period to all ones
// and drops out_valid. The segment memory itself is not cleared; only entries
// below the count are ever read. When the receiver stalls, the response holds
// in the output register and the next response waits in the sequencer.
module circular_segment_overlap_sum_core #(
  parameter int MAX_SEGMENTS = 64,
  parameter int TIME_BITS    = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [csos_pkg::PERIOD_W-1:0]       cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_command,
  input  logic [TIME_BITS-1:0]                in_time_a,
  input  logic [TIME_BITS-1:0]                in_time_b,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [csos_pkg::AMOUNT_W-1:0]       out_amount,
  output logic                                out_error
);

  localparam int PW = csos_pkg::PERIOD_W;
  localparam int AW = csos_pkg::AMOUNT_W;
  localparam int TW = csos_pkg::TERM_W;
  // Times are limited to both the port width and the period width.
  localparam int EW = (TIME_BITS < PW) ? TIME_BITS : PW;
  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  csos_pkg::csos_state_t state_r, state_nxt;

  logic [PW-1:0] period_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          sp_r, sp_nxt;
  logic          qp_r, qp_nxt;
  logic [PW-1:0] ta_r, ta_nxt;
  logic [PW-1:0] tb_r, tb_nxt;
  logic          is_len_r, is_len_nxt;
  logic          q_wrap_r, q_wrap_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_amount_r, out_amount_nxt;
  logic          out_error_r, out_error_nxt;

  logic [PW-1:0] starts_mem [MAX_SEGMENTS];
  logic [PW-1:0] ends_mem   [MAX_SEGMENTS];
  logic [PW-1:0] rd_s_r, rd_e_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;

  csos_pkg::csos_cmd_t cmd;
  logic [PW-1:0] ta_eff, tb_eff;
  logic          in_fire, out_free, bad_time, list_full, start_walk;

  logic          seg_wrap, sp_last, qp_last, seg_done, last_seg;
  logic [CW-1:0] idx_inc;
  logic [PW-1:0] a0, a1, b0, b1;
  logic [TW-1:0] lo, hi, fallback, term;
  logic [AW:0]   acc_sum;

  assign cmd      = csos_pkg::csos_cmd_t'(in_command);
  assign ta_eff   = PW'(in_time_a[EW-1:0]);
  assign tb_eff   = PW'(in_time_b[EW-1:0]);
  assign in_ready = (state_r == csos_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign bad_time = (ta_eff >= period_r) || (tb_eff >= period_r);
  assign list_full = (count_r >= CW'(MAX_SEGMENTS));
  assign start_walk = (((cmd == csos_pkg::CMD_OVERLAP) && !bad_time) ||
                       (cmd == csos_pkg::CMD_LENGTH)) && (count_r != '0);

  // Piece enumeration for the segment under work. A wrapped segment splits
  // into [0,e] and [s,period]; a wrapped query into [0,tb] and [ta,period].
  // The length query always uses one piece per segment.
  assign seg_wrap = (rd_e_r <= rd_s_r);
  assign sp_last  = is_len_r || !seg_wrap || sp_r;
  assign qp_last  = !q_wrap_r || qp_r;
  assign seg_done = sp_last && qp_last;
  assign idx_inc  = idx_r + CW'(1);
  assign last_seg = (idx_inc == count_r);

  assign a0 = (seg_wrap && !sp_r) ? '0 : rd_s_r;
  assign a1 = (seg_wrap && sp_r) ? period_r : rd_e_r;
  assign b0 = (q_wrap_r && !qp_r) ? '0 : ta_r;
  assign b1 = (q_wrap_r && qp_r) ? period_r : tb_r;

  // Shared unit: one clip and subtract per cycle. For the length query the
  // bounds are the segment itself, with the wrapped form measured from
  // period + end; if that still falls short of the start, only the part
  // from zero to the end counts.
  always_comb begin
    if (is_len_r) begin
      lo       = TW'(rd_s_r);
      hi       = seg_wrap ? (TW'(period_r) + TW'(rd_e_r)) : TW'(rd_e_r);
      fallback = (seg_wrap && (hi != lo)) ? TW'(rd_e_r) : '0;
    end else begin
      lo       = TW'((a0 > b0) ? a0 : b0);
      hi       = TW'((a1 < b1) ? a1 : b1);
      fallback = '0;
    end
    term    = (hi > lo) ? (hi - lo) : fallback;
    acc_sum = {1'b0, acc_r} + (AW + 1)'(term);
  end

  always_comb begin
    case (state_r)
      csos_pkg::ST_IDLE: begin
        rd_addr = '0;
      end
      csos_pkg::ST_WALK: begin
        rd_addr = seg_done ? idx_inc[IW-1:0] : idx_r[IW-1:0];
      end
      default: begin
        rd_addr = idx_r[IW-1:0];
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csos_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = start_walk ? csos_pkg::ST_WALK : csos_pkg::ST_RESULT;
        end
      end
      csos_pkg::ST_WALK: begin
        if (seg_done && last_seg) begin
          state_nxt = csos_pkg::ST_RESULT;
        end
      end
      csos_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = csos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = csos_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    sp_nxt         = sp_r;
    qp_nxt         = qp_r;
    ta_nxt         = ta_r;
    tb_nxt         = tb_r;
    is_len_nxt     = is_len_r;
    q_wrap_nxt     = q_wrap_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    mem_we         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_amount_nxt = out_amount_r;
    out_error_nxt  = out_error_r;
    case (state_r)
      csos_pkg::ST_IDLE: begin
        if (in_fire) begin
          idx_nxt    = '0;
          sp_nxt     = 1'b0;
          qp_nxt     = 1'b0;
          ta_nxt     = ta_eff;
          tb_nxt     = tb_eff;
          acc_nxt    = '0;
          err_nxt    = 1'b0;
          is_len_nxt = (cmd == csos_pkg::CMD_LENGTH);
          q_wrap_nxt = (cmd == csos_pkg::CMD_OVERLAP) && (ta_eff > tb_eff);
          case (cmd)
            csos_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            csos_pkg::CMD_APPEND: begin
              if (list_full || bad_time) begin
                err_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            csos_pkg::CMD_OVERLAP: begin
              err_nxt = bad_time;
            end
            default: begin
              err_nxt = 1'b0;
            end
          endcase
        end
      end
      csos_pkg::ST_WALK: begin
        // The sum only grows, so clamping each step equals clamping the total.
        acc_nxt = acc_sum[AW] ? csos_pkg::AMOUNT_SAT : acc_sum[AW-1:0];
        if (!sp_last) begin
          sp_nxt = 1'b1;
        end else begin
          sp_nxt = 1'b0;
          qp_nxt = !qp_last;
        end
        if (seg_done) begin
          idx_nxt = idx_inc;
        end
      end
      csos_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_amount_nxt = acc_r;
          out_error_nxt  = err_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csos_pkg::ST_IDLE;
      period_r    <= csos_pkg::PERIOD_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    sp_r         <= sp_nxt;
    qp_r         <= qp_nxt;
    ta_r         <= ta_nxt;
    tb_r         <= tb_nxt;
    is_len_r     <= is_len_nxt;
    q_wrap_r     <= q_wrap_nxt;
    acc_r        <= acc_nxt;
    err_r        <= err_nxt;
    out_amount_r <= out_amount_nxt;
    out_error_r  <= out_error_nxt;
  end

  // Segment list memory: one write port for appends, one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      starts_mem[count_r[IW-1:0]] <= ta_eff;
      ends_mem[count_r[IW-1:0]]   <= tb_eff;
    end
    rd_s_r <= starts_mem[rd_addr];
    rd_e_r <= ends_mem[rd_addr];
  end

  assign out_valid  = out_valid_r;
  assign out_amount = out_amount_r;
  assign out_error  = out_error_r;

endmodule

/* design/csos_checker.sv */
// Port-level checker for the circular segment overlap sum core, with its bind.
// Depends on csos_pkg and circular_segment_overlap_sum_core.
module csos_checker #(
  parameter int TIME_BITS = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    in_command,
  input logic [TIME_BITS-1:0]          in_time_a,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [csos_pkg::AMOUNT_W-1:0] out_amount,
  input logic                          out_error
);

  // Reset leaves no response pending.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("response valid right after reset");

  // A flagged response never carries an amount.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_amount == '0)
    else $error("error response with nonzero amount");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in progress");

  // A stalled response holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_amount) && $stable(out_error))
    else $error("stalled response changed");

  // An accepted request carries a known command and a known start time.
  a_known_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !$isunknown(in_command) && !$isunknown(in_time_a))
    else $error("request accepted with unknown command or time");

endmodule

bind circular_segment_overlap_sum_core csos_checker #(.TIME_BITS(TIME_BITS)) u_csos_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_command (in_command),
  .in_time_a  (in_time_a),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_amount (out_amount),
  .out_error  (out_error)
);
